>>> rtl/nrph_pkg.sv
// Shared types and constants for the NUL-separated record parser.
// No dependencies; used by nul_record_parse_hash_route.
package nrph_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NUM_W  = 64;
	localparam int unsigned HASH_W = 32;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned POS_W  = 2;

	// Padded width of the result tdata: 64 + 64 + 32 + 1 + 16 + 1 = 178, up to 184.
	localparam int unsigned OUT_FIELDS_W = 2 * NUM_W + HASH_W + 1 + LEN_W + 1;
	localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
	localparam logic [LEN_W-1:0]  LEN_MAX   = '1;
	localparam logic [NUM_W-1:0]  NUM_MAX   = '1;

	// Fold of the hash bytes into a small residue sum: four terms of at most 255 * 255.
	localparam int unsigned FOLD_W      = 18;
	localparam int unsigned RECIP_SHIFT = 27;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

	typedef enum logic [POS_W-1:0] {
		POS_STAMP = 2'd0,
		POS_PATH  = 2'd1,
		POS_SIZE  = 2'd2,
		POS_SPARE = 2'd3
	} field_pos_t;

	typedef struct packed {
		logic [LEN_W-1:0]  path_length;
		logic              overflowed;
		logic [HASH_W-1:0] path_hash;
		logic [NUM_W-1:0]  file_bytes;
		logic [NUM_W-1:0]  stamp_seconds;
	} rec_t;

endpackage

>>> rtl/nul_record_parse_hash_route.sv
// Top level of the NUL-separated record parser with djb2 hash routing.
// Depends on nrph_pkg for field widths, constants and the record struct.
//
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------------
// s_axis   | in  | s_axis_tvalid/tready    | tdata[7:0] data_byte
// m_axis   | out | m_axis_tvalid/tready    | tdata[183:0] record result (see port)
//
// One byte is accepted per cycle while s_axis_tready is high. The parser state
// updates in the cycle a byte is accepted; a record's closing NUL loads stage 1,
// the hash residue is folded in stage 2 and the target is resolved by a reciprocal
// multiply into stage 3, which drives m_axis.
// arst_n resets the parser state (hash_q to HASH_SEED) and clears all stage valid bits.
// A stalled m_axis holds stage 3; earlier stages keep filling bubbles, and
// s_axis_tready drops only while m_axis stalls with all three stages holding results.
module nul_record_parse_hash_route #(
	parameter int unsigned NUM_TARGETS = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [nrph_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] data_byte
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [63:0] stamp_seconds, [127:64] file_bytes, [159:128] path_hash,
	// [160] target_index, [176:161] path_length, [177] overflowed, [183:178] zero
	output logic [nrph_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int unsigned FW = nrph_pkg::FOLD_W;
	localparam int unsigned RS = nrph_pkg::RECIP_SHIFT;
	localparam int unsigned RW = nrph_pkg::RECIP_W;

	// Residue of 256^k for each hash byte, so the folded sum keeps hash mod NUM_TARGETS.
	localparam logic [7:0] FOLD_C0 = 8'((64'd1 <<  0) % NUM_TARGETS);
	localparam logic [7:0] FOLD_C1 = 8'((64'd1 <<  8) % NUM_TARGETS);
	localparam logic [7:0] FOLD_C2 = 8'((64'd1 << 16) % NUM_TARGETS);
	localparam logic [7:0] FOLD_C3 = 8'((64'd1 << 24) % NUM_TARGETS);
	localparam logic [RW-1:0] RECIP_M = RW'(((64'd1 << RS) + NUM_TARGETS - 1) / NUM_TARGETS);
	localparam logic [8:0]    NT      = 9'(NUM_TARGETS);

	// Parser state
	nrph_pkg::field_pos_t               pos_q;
	logic [nrph_pkg::NUM_W-1:0]         secs_q, size_q;
	logic [nrph_pkg::HASH_W-1:0]        hash_q;
	logic [nrph_pkg::LEN_W-1:0]         len_q;
	logic                               ended_q, empty_q, sat_q, has_bytes_q;

	// Pipeline
	logic                   vld_s1, vld_s2, vld_s3;
	nrph_pkg::rec_t         rec_s1, rec_s2, rec_s3;
	logic [FW-1:0]          fold_s2;
	logic                   tgt_s3;
	logic                   adv1, adv2, adv3;
	logic                   take;

	// Combinational next values
	logic [nrph_pkg::BYTE_W-1:0]        b;
	logic                               is_nul, is_digit, in_stamp, in_path;
	logic [nrph_pkg::NUM_W-1:0]         dig_acc;
	logic [nrph_pkg::NUM_W+3:0]         dig_wide;
	logic [nrph_pkg::NUM_W-1:0]         dig_next;
	logic                               dig_sat;
	logic [nrph_pkg::HASH_W-1:0]        hash_next;
	logic                               empty_now, emit;
	logic [FW-1:0]                      fold_sum;
	logic [FW+RW-1:0]                   recip_prod;

	assign adv3          = !vld_s3 || m_axis_tready;
	assign adv2          = !vld_s2 || adv3;
	assign adv1          = !vld_s1 || adv2;
	assign s_axis_tready = adv1;
	assign take          = s_axis_tvalid && adv1;

	assign b        = s_axis_tdata;
	assign is_nul   = (b == '0);
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);
	assign in_stamp = (pos_q == nrph_pkg::POS_STAMP);
	assign in_path  = (pos_q == nrph_pkg::POS_PATH);

	// Shared decimal step: acc * 10 + digit, saturate on carry out of 64 bits.
	assign dig_acc  = in_stamp ? secs_q : size_q;
	assign dig_wide = {1'b0, dig_acc, 3'b000} + {3'b000, dig_acc, 1'b0} + 68'(b - 8'h30);
	assign dig_sat  = (dig_wide[nrph_pkg::NUM_W+3:nrph_pkg::NUM_W] != '0);
	assign dig_next = dig_sat ? nrph_pkg::NUM_MAX : dig_wide[nrph_pkg::NUM_W-1:0];

	assign hash_next = {hash_q[nrph_pkg::HASH_W-6:0], 5'b00000} + hash_q
		+ {{(nrph_pkg::HASH_W - nrph_pkg::BYTE_W){b[7]}}, b};

	assign empty_now = empty_q || !has_bytes_q;
	assign emit      = take && is_nul && !in_stamp && !in_path && !empty_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= nrph_pkg::POS_STAMP;
			secs_q      <= '0;
			size_q      <= '0;
			hash_q      <= nrph_pkg::HASH_SEED;
			len_q       <= '0;
			ended_q     <= 1'b0;
			empty_q     <= 1'b0;
			sat_q       <= 1'b0;
			has_bytes_q <= 1'b0;
		end else if (take) begin
			if (is_nul) begin
				has_bytes_q <= 1'b0;
				ended_q     <= 1'b0;
				if (in_stamp || in_path) begin
					pos_q   <= nrph_pkg::field_pos_t'(pos_q + 2'd1);
					empty_q <= empty_now;
				end else begin
					// record closed: emitted or dropped, start over
					pos_q   <= nrph_pkg::POS_STAMP;
					secs_q  <= '0;
					size_q  <= '0;
					hash_q  <= nrph_pkg::HASH_SEED;
					len_q   <= '0;
					empty_q <= 1'b0;
					sat_q   <= 1'b0;
				end
			end else begin
				has_bytes_q <= 1'b1;
				if (in_path) begin
					hash_q <= hash_next;
					if (len_q == nrph_pkg::LEN_MAX) begin
						sat_q <= 1'b1;
					end else begin
						len_q <= len_q + 16'd1;
					end
				end else if (!ended_q) begin
					if (!is_digit) begin
						ended_q <= 1'b1;
					end else begin
						if (dig_sat) begin
							sat_q <= 1'b1;
						end
						if (in_stamp) begin
							secs_q <= dig_next;
						end else begin
							size_q <= dig_next;
						end
					end
				end
			end
		end
	end

	// Fold the hash bytes by their residues; the sum is congruent to hash mod NUM_TARGETS.
	always_comb begin
		fold_sum = FW'(rec_s1.path_hash[7:0])   * FW'(FOLD_C0)
			+ FW'(rec_s1.path_hash[15:8])  * FW'(FOLD_C1)
			+ FW'(rec_s1.path_hash[23:16]) * FW'(FOLD_C2)
			+ FW'(rec_s1.path_hash[31:24]) * FW'(FOLD_C3);
	end

	// Quotient by reciprocal; only bit 0 of sum - q * N is needed.
	assign recip_prod = (FW+RW)'(fold_s2) * (FW+RW)'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= emit;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && emit) begin
			rec_s1.stamp_seconds <= secs_q;
			rec_s1.file_bytes    <= size_q;
			rec_s1.path_hash     <= hash_q;
			rec_s1.path_length   <= len_q;
			rec_s1.overflowed    <= sat_q;
		end
		if (adv2) begin
			rec_s2  <= rec_s1;
			fold_s2 <= fold_sum;
		end
		if (adv3) begin
			rec_s3 <= rec_s2;
			tgt_s3 <= fold_s2[0] ^ (recip_prod[RS] & NT[0]);
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = nrph_pkg::OUT_DATA_W'({
		rec_s3.overflowed,
		rec_s3.path_length,
		tgt_s3,
		rec_s3.path_hash,
		rec_s3.file_bytes,
		rec_s3.stamp_seconds
	});

endmodule
